// ----- sv/cfbm_pkg.sv -----
package cfbm_pkg;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;
  localparam int BANK_W = 5;
  localparam int RAM_AW = 8;
  localparam int BANK_BYTES = 16384;

  localparam logic [1:0] CMD_BUS      = 2'd0;
  localparam logic [1:0] CMD_LOAD_ROM = 2'd1;
  localparam logic [1:0] CMD_LOAD_MAP = 2'd2;

  localparam logic [7:0] OFF_BANK = 8'h00;
  localparam logic [7:0] OFF_CTRL = 8'h02;

  localparam logic [DATA_W-1:0] OOB_BYTE = 8'hFF;

  localparam logic REG_INITIAL_EXROM = 1'b0;
  localparam logic REG_INITIAL_GAME  = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              read_not_write;
    logic [ADDR_W-1:0] addr;
    logic              roml_n;
    logic              romh_n;
    logic              io1_n;
    logic              io2_n;
    logic [DATA_W-1:0] data;
    logic [BANK_W-1:0] load_bank;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] bus_byte;
    logic              drive;
    logic              exrom_line;
    logic              game_line;
  } rsp_t;

  // Decoded item held while its memory reads complete.
  typedef struct packed {
    logic rom_rd;
    logic ram_rd;
    logic bank_wr;
    logic ctrl_wr;
    logic bank_oob;
    logic exrom_new;
    logic game_new;
  } ctl_t;

endpackage

// ----- sv/cfbm_ram.sv -----
module cfbm_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/cfbm_io_ram.sv -----
module cfbm_io_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [cfbm_pkg::RAM_AW-1:0] waddr,
  input  logic [cfbm_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [cfbm_pkg::RAM_AW-1:0] raddr,
  output logic [cfbm_pkg::DATA_W-1:0] rdata
);
  import cfbm_pkg::*;

  localparam int DEPTH = 1 << RAM_AW;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q   <= mem[raddr];
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

// ----- sv/flash_cartridge_bank_mapper_unit.sv -----
// Cartridge-side bank mapper. Each accepted item is one host bus cycle or one
// load command and yields exactly one result item. The block takes one item
// per clock while the input is not stalled: an item reads its memories (ROM
// store, bank map, I/O RAM, each a single synchronous port) as it is
// accepted, is decoded into a one-entry hold stage, and moves on into the
// output register once that register is empty or not stalled.
// The input stalls only while the hold stage is full and the output register
// is full and stalled. Writes to the bank register go through the bank map;
// the mapped bank is committed when that item leaves the hold stage and is
// forwarded to a ROM read accepted in the same cycle, so back-to-back bank
// switch and read cost nothing extra. The I/O RAM starts zeroed through
// per-entry valid bits, so there is no clearing pass after reset. ROM store
// and bank map contents are undefined until loaded. EXROM and GAME follow the
// initial-level registers until the host writes the control register.
module flash_cartridge_bank_mapper_unit #(
  parameter int BANK_COUNT = 32,
  parameter int MAP_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cfbm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cfbm_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_data
);
  import cfbm_pkg::*;

  localparam int ROM_DEPTH = BANK_COUNT * BANK_BYTES;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int MAP_AW = $clog2(MAP_ENTRIES);

  // Architectural state
  logic [BANK_W-1:0] current_bank;
  logic              line_exrom;
  logic              line_game;
  logic              ctrl_written;

  // Hold stage and output register
  logic              s1_valid;
  ctl_t              s1;
  ctl_t              s1_next;
  logic              s1_adv;
  logic              accept;
  rsp_t              rsp_next;

  // Decode of the incoming item
  logic              is_bus;
  logic              rom_ld;
  logic              map_ld;
  logic              ram_wr;
  logic [BANK_W-1:0] bank_eff;

  // Memory ports
  logic [ROM_AW-1:0] rom_raddr;
  logic [ROM_AW-1:0] rom_waddr;
  logic [DATA_W-1:0] rom_rdata;
  logic [BANK_W-1:0] map_rdata;
  logic [DATA_W-1:0] ram_rdata;

  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;

  // A bank write still in the hold stage is younger than nothing and older
  // than the item now arriving: forward its mapped bank.
  assign bank_eff = (s1_valid && s1.bank_wr) ? map_rdata : current_bank;

  always_comb begin
    is_bus = (req.cmd == CMD_BUS);
    rom_ld = (req.cmd == CMD_LOAD_ROM) && (32'(req.load_bank) < BANK_COUNT);
    map_ld = (req.cmd == CMD_LOAD_MAP) && (32'(req.addr) < MAP_ENTRIES);
    ram_wr = is_bus && !req.read_not_write && req.io1_n && !req.io2_n;

    s1_next.rom_rd   = is_bus && req.read_not_write && (!req.roml_n || !req.romh_n);
    // ROM window wins over IO2 on a read
    s1_next.ram_rd   = is_bus && req.read_not_write && req.roml_n && req.romh_n
                       && !req.io2_n;
    s1_next.bank_wr  = is_bus && !req.read_not_write && !req.io1_n
                       && (req.addr[7:0] == OFF_BANK);
    s1_next.ctrl_wr  = is_bus && !req.read_not_write && !req.io1_n
                       && (req.addr[7:0] == OFF_CTRL);
    s1_next.bank_oob = (32'(bank_eff) >= BANK_COUNT);
    s1_next.exrom_new = ~req.data[1];
    s1_next.game_new  = ~req.data[0];

    rom_raddr = (ROM_AW'(bank_eff) << ADDR_W) | ROM_AW'(req.addr);
    rom_waddr = (ROM_AW'(req.load_bank) << ADDR_W) | ROM_AW'(req.addr);
  end

  cfbm_ram #(
    .DW    (DATA_W),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (accept && rom_ld),
    .waddr (rom_waddr),
    .wdata (req.data),
    .re    (accept),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  cfbm_ram #(
    .DW    (BANK_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (accept && map_ld),
    .waddr (req.addr[MAP_AW-1:0]),
    .wdata (req.data[BANK_W-1:0]),
    .re    (accept),
    .raddr (req.data[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  cfbm_io_ram u_io_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (accept && ram_wr),
    .waddr (req.addr[RAM_AW-1:0]),
    .wdata (req.data),
    .re    (accept),
    .raddr (req.addr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result of the held item; line levels are those after this step.
  always_comb begin
    rsp_next.drive      = s1.rom_rd || s1.ram_rd;
    rsp_next.bus_byte   = '0;
    if (s1.rom_rd) begin
      rsp_next.bus_byte = s1.bank_oob ? OOB_BYTE : rom_rdata;
    end else if (s1.ram_rd) begin
      rsp_next.bus_byte = ram_rdata;
    end
    rsp_next.exrom_line = s1.ctrl_wr ? s1.exrom_new : line_exrom;
    rsp_next.game_line  = s1.ctrl_wr ? s1.game_new : line_game;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

  // Commit state as the item leaves the hold stage; config writes are to arrive idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_bank <= '0;
      line_exrom   <= 1'b1;
      line_game    <= 1'b0;
      ctrl_written <= 1'b0;
    end else begin
      if (s1_adv && s1.bank_wr) begin
        current_bank <= map_rdata;
      end
      if (s1_adv && s1.ctrl_wr) begin
        line_exrom   <= s1.exrom_new;
        line_game    <= s1.game_new;
        ctrl_written <= 1'b1;
      end else if (cfg_we && !ctrl_written) begin
        if (cfg_index == REG_INITIAL_EXROM) begin
          line_exrom <= cfg_data;
        end
        if (cfg_index == REG_INITIAL_GAME) begin
          line_game <= cfg_data;
        end
      end
    end
  end

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |-> req_stall)
    else $error("input accepted while hold stage is blocked");

  a_quiet_bus: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.drive |-> rsp.bus_byte == '0)
    else $error("nonzero data on a non-driving result");

  a_ctrl_sticky: assert property (@(posedge clk) disable iff (rst)
    ctrl_written |=> ctrl_written)
    else $error("control-written flag cleared without reset");

  a_bank_commit: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.bank_wr |=> current_bank == $past(map_rdata))
    else $error("mapped bank not committed");

endmodule
